// ===== rtl/adpcm_pkg.sv =====
// Shared types, constants and coefficient lookup for the ADPCM block decoder.
package adpcm_pkg;

    localparam int WORD_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int SHIFT_W  = 4;
    localparam int FILTER_W = 4;
    localparam int COEF_W   = 8;
    localparam int NIB_W    = 4;
    localparam int NIB_IDX_W = 2;
    localparam int NUM_FILTERS = 5;

    localparam logic [NIB_IDX_W-1:0] LAST_NIB = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Fraction bits dropped by the divide-by-64 of the prediction, after a rounding term is added
    localparam int PRED_FRAC_W = 6;

    localparam logic signed [COEF_W-1:0] COEF_ONE [NUM_FILTERS] =
        '{8'sd0, 8'sd60, 8'sd115, 8'sd98, 8'sd122};
    localparam logic signed [COEF_W-1:0] COEF_TWO [NUM_FILTERS] =
        '{8'sd0, 8'sd0, -8'sd52, -8'sd55, -8'sd60};

    typedef enum logic {
        KIND_DATA,
        KIND_HEADER
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] word;
    } qentry_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        logic                 emit;
        logic [NIB_IDX_W-1:0] nib_idx;
    } back_status_t;

    function automatic logic signed [COEF_W-1:0] coef_one(input logic [FILTER_W-1:0] id);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (id < FILTER_W'(NUM_FILTERS))
        begin
            c = COEF_ONE[id[2:0]];
        end
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_two(input logic [FILTER_W-1:0] id);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (id < FILTER_W'(NUM_FILTERS))
        begin
            c = COEF_TWO[id[2:0]];
        end
        return c;
    endfunction

endpackage

// ===== rtl/adpcm_front.sv =====
// Front end: accepts block words, tags header or data, and queues them.
module adpcm_front #(
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [15:0]                word_in,
    input  logic                       is_header,
    output adpcm_pkg::qentry_t         q_entry,
    output logic                       q_valid,
    input  logic                       q_pop,
    output logic [$clog2(DEPTH+1)-1:0] q_count
);
    import adpcm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem [DEPTH];
    qentry_t            entry_in;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    always_comb
    begin
        entry_in.kind = is_header ? KIND_HEADER : KIND_DATA;
        entry_in.word = word_in;
    end

    assign in_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem[rd_ptr_reg];
    assign q_count  = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/adpcm_back.sv =====
// Back end: applies headers and decodes data words one sample per cycle while the output keeps up.
module adpcm_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  adpcm_pkg::qentry_t       q_entry,
    input  logic                     q_valid,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [15:0]       sample_out,
    output logic                     last_of_word,
    output adpcm_pkg::back_status_t  status
);
    import adpcm_pkg::*;

    back_state_t                   state_reg, state_next;
    logic [WORD_W-1:0]             word_reg;
    logic [NIB_IDX_W-1:0]          nib_reg;
    logic signed [SAMPLE_W-1:0]    hist1_reg, hist2_reg;
    logic [SHIFT_W-1:0]            shift_reg;
    logic [FILTER_W-1:0]           filter_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0]    sample_reg;
    logic                          last_reg;

    logic                          can_emit, emit, load_word, latch_hdr, next_is_data;
    logic [NIB_W-1:0]              nibble;
    logic signed [SAMPLE_W-1:0]    data_val;
    logic signed [COEF_W-1:0]      c1, c2;
    logic signed [SAMPLE_W+COEF_W-1:0] prod1, prod2;
    logic signed [SAMPLE_W+COEF_W+1:0] pred_sum;
    logic signed [SAMPLE_W+COEF_W+1-PRED_FRAC_W:0] pred;
    logic signed [SAMPLE_W+COEF_W+2-PRED_FRAC_W:0] total;
    logic signed [SAMPLE_W-1:0]    sample;

    assign can_emit     = !out_valid_reg || out_ready;
    assign next_is_data = q_valid && (q_entry.kind == KIND_DATA);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (next_is_data)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (can_emit && (nib_reg == LAST_NIB) && !next_is_data)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop     = 1'b0;
        load_word = 1'b0;
        latch_hdr = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    latch_hdr = (q_entry.kind == KIND_HEADER);
                    load_word = (q_entry.kind == KIND_DATA);
                end
            end
            BK_RUN:
            begin
                emit = can_emit;
                // chain straight into the next data word on the last sample
                if (can_emit && (nib_reg == LAST_NIB) && next_is_data)
                begin
                    q_pop     = 1'b1;
                    load_word = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Sample datapath
    always_comb
    begin
        nibble   = word_reg[{nib_reg, 2'b00} +: NIB_W];
        data_val = $signed({nibble, {(SAMPLE_W-NIB_W){1'b0}}}) >>> shift_reg;
        c1       = coef_one(filter_reg);
        c2       = coef_two(filter_reg);
        prod1    = c1 * hist1_reg;
        prod2    = c2 * hist2_reg;
        pred_sum = (SAMPLE_W+COEF_W+2)'(prod1) + (SAMPLE_W+COEF_W+2)'(prod2)
                 + (SAMPLE_W+COEF_W+2)'(signed'(32'sd32));
        pred     = pred_sum[SAMPLE_W+COEF_W+1:PRED_FRAC_W];
        total    = (SAMPLE_W+COEF_W+3-PRED_FRAC_W)'(pred)
                 + (SAMPLE_W+COEF_W+3-PRED_FRAC_W)'(data_val);
        priority if (total > (SAMPLE_W+COEF_W+3-PRED_FRAC_W)'(SAMPLE_MAX))
        begin
            sample = SAMPLE_MAX;
        end
        else if (total < (SAMPLE_W+COEF_W+3-PRED_FRAC_W)'(SAMPLE_MIN))
        begin
            sample = SAMPLE_MIN;
        end
        else
        begin
            sample = total[SAMPLE_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_word)
        begin
            word_reg <= q_entry.word;
        end
        if (emit)
        begin
            sample_reg <= sample;
            last_reg   <= (nib_reg == LAST_NIB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            nib_reg       <= '0;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            shift_reg     <= '0;
            filter_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (latch_hdr)
            begin
                shift_reg  <= q_entry.word[3:0];
                filter_reg <= q_entry.word[7:4];
            end
            if (load_word)
            begin
                nib_reg <= '0;
            end
            else if (emit)
            begin
                nib_reg <= nib_reg + 1'b1;
            end
            if (emit)
            begin
                hist2_reg <= hist1_reg;
                hist1_reg <= sample;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_out     = sample_reg;
    assign last_of_word   = last_reg;
    assign status.emit    = emit;
    assign status.nib_idx = nib_reg;

endmodule

// ===== rtl/adpcm_block_decoder.sv =====
// Top level of the 4-bit ADPCM block decoder: front queue, decode back end, checks.
// A header word is taken into the queue and applied by the back end without
// producing a sample. A data word produces four samples, one per cycle while the
// output keeps up, because each sample's prediction needs the one before it
// through the single shared predictor (two 8x16 multiplies, add, round, clamp).
// Back-to-back data words chain with no loading gap while the output keeps up. A
// data word that reaches an idle back end is loaded before its first sample, so a
// header between two data words adds a step to apply it and a step to reload.
// The input queue of QUEUE_DEPTH entries (at least 2) keeps accepting words until
// full while the output is stalled; the output register holds a sample until taken.
module adpcm_block_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        word_in,
    input  logic               is_header,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out,
    output logic               last_of_word
);
    import adpcm_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qentry_t      q_entry;
    logic         q_valid;
    logic         q_pop;
    logic [CNT_W-1:0] q_count;
    back_status_t back_status;

    adpcm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .word_in   (word_in),
        .is_header (is_header),
        .q_entry   (q_entry),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_count   (q_count)
    );

    adpcm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_entry      (q_entry),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .last_of_word (last_of_word),
        .status       (back_status)
    );

    // Queue never overfills and stalls input only when full
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("input queue count exceeds depth");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (q_count == CNT_W'(QUEUE_DEPTH)))
        else $error("input stalled with queue space left");

    // Never overwrite a sample that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.emit |-> (!out_valid || out_ready))
        else $error("sample overwritten before transaction completed");

    // Last flag follows the nibble position of the emitted sample
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.emit |=>
            (out_valid && (last_of_word == ($past(back_status.nib_idx) == LAST_NIB))))
        else $error("last_of_word does not match nibble position");

endmodule

// ===== dv/adpcm_block_decoder_test.sv =====
// Self-checking testbench for the ADPCM block decoder: directed and random blocks.
module adpcm_block_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import adpcm_pkg::*;

    localparam logic [3:0] FILTER_FLAT      = 4'd0;
    localparam logic [3:0] FILTER_LINEAR    = 4'd1;
    localparam logic [3:0] FILTER_QUAD_A    = 4'd2;
    localparam logic [3:0] FILTER_QUAD_B    = 4'd3;
    localparam logic [3:0] FILTER_QUAD_C    = 4'd4;
    localparam logic [3:0] FILTER_UNUSED_LO = 4'd5;
    localparam logic [3:0] FILTER_UNUSED_HI = 4'd15;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } pcm_sample_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        word_in;
    logic               is_header;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sample_out;
    logic               last_of_word;

    // Decoder state as seen by the testbench
    logic signed [15:0] prev_sample;
    logic signed [15:0] prev_prev_sample;
    logic [3:0]         cur_shift;
    logic [3:0]         cur_filter;

    pcm_sample_t pcm_expected[$];

    int         mismatch_count  = 0;
    int         samples_checked = 0;
    int         words_sent      = 0;
    int         headers_sent    = 0;
    bit         src_gaps        = 1'b0;
    int         burst_left      = 0;
    sink_mode_t sink_mode       = SINK_OPEN;
    int         sink_hold       = 0;

    adpcm_block_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word_in      (word_in),
        .is_header    (is_header),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_out   (sample_out),
        .last_of_word (last_of_word)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [15:0] header_word(input logic [7:0] flags, input logic [3:0] filt,
                                                input logic [3:0] shift);
        return {flags, filt, shift};
    endfunction

    function automatic void predictor_gains(input logic [3:0] filt, output int gain_a,
                                            output int gain_b);
        case (filt)
            FILTER_LINEAR:
            begin
                gain_a = 60;
                gain_b = 0;
            end
            FILTER_QUAD_A:
            begin
                gain_a = 115;
                gain_b = -52;
            end
            FILTER_QUAD_B:
            begin
                gain_a = 98;
                gain_b = -55;
            end
            FILTER_QUAD_C:
            begin
                gain_a = 122;
                gain_b = -60;
            end
            default:
            begin
                gain_a = 0;
                gain_b = 0;
            end
        endcase
    endfunction

    // Expand one data word into its four samples, advancing the history.
    function automatic void decode_word(input logic [15:0] w);
        logic signed [3:0] nib;
        int                step;
        int                pred;
        int                total;
        int                gain_a;
        int                gain_b;
        pcm_sample_t       pcm;
        predictor_gains(cur_filter, gain_a, gain_b);
        for (int k = 0; k < 4; k++)
        begin
            nib = w[4*k +: 4];
            step = int'(nib);
            if (cur_shift <= 4'd12)
                step = step <<< (12 - int'(cur_shift));
            else
                step = step >>> (int'(cur_shift) - 12);
            pred = (gain_a * prev_sample + gain_b * prev_prev_sample + 32) >>> 6;
            total = step + pred;
            if (total > 32767)
                total = 32767;
            if (total < -32768)
                total = -32768;
            pcm.sample = total[15:0];
            pcm.last = (k == 3);
            pcm_expected.push_back(pcm);
            prev_prev_sample = prev_sample;
            prev_sample = pcm.sample;
        end
    endfunction

    // Offer one word, hold it until the transaction completes, then maybe pause.
    task automatic feed_word(input logic [15:0] w, input kind_t kind);
        in_valid  <= 1'b1;
        word_in   <= w;
        is_header <= kind;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        if (kind == KIND_HEADER)
        begin
            cur_shift  = w[3:0];
            cur_filter = w[7:4];
            headers_sent++;
        end
        else
        begin
            decode_word(w);
        end
        if (src_gaps)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = $urandom_range(1, 10);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // One header with random shift and filter, followed by data words with random content.
    task automatic send_block(input int n_data);
        logic [3:0] filt;
        logic [3:0] shift;
        filt  = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(5, 15));
        shift = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 12)) : 4'($urandom_range(13, 15));
        feed_word(header_word(8'($urandom_range(0, 255)), filt, shift), KIND_HEADER);
        repeat (n_data) feed_word(16'($urandom_range(0, 16'hFFFF)), KIND_DATA);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pcm_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_reset_state();
        src_gaps  = 1'b0;
        sink_mode = SINK_OPEN;
        feed_word(16'h8F70, KIND_DATA);
        feed_word(16'h7777, KIND_DATA);
        wait_drained();
    endtask

    task automatic test_filters_and_shifts();
        logic [3:0]  filt_list[7];
        logic [3:0]  shift_list[7];
        logic [15:0] data_list[7];
        filt_list  = '{FILTER_FLAT, FILTER_LINEAR, FILTER_QUAD_A, FILTER_QUAD_B,
                       FILTER_QUAD_C, FILTER_UNUSED_LO, FILTER_UNUSED_HI};
        shift_list = '{4'd0, 4'd12, 4'd13, 4'd15, 4'd1, 4'd7, 4'd4};
        data_list  = '{16'h1234, 16'hFEDC, 16'h8F7F, 16'h9ACE, 16'h7B3C, 16'h4D2E, 16'hC0A1};
        src_gaps  = 1'b1;
        sink_mode = SINK_RANDOM;
        for (int i = 0; i < 7; i++)
        begin
            feed_word(header_word((i % 2) ? 8'hFF : 8'h00, filt_list[i], shift_list[i]),
                      KIND_HEADER);
            feed_word(data_list[i], KIND_DATA);
        end
        wait_drained();
    endtask

    task automatic test_saturation();
        src_gaps  = 1'b0;
        sink_mode = SINK_PATTERN;
        feed_word(header_word(8'h00, FILTER_LINEAR, 4'd0), KIND_HEADER);
        feed_word(16'h7777, KIND_DATA);
        feed_word(16'h8888, KIND_DATA);
        wait_drained();
    endtask

    task automatic test_header_runs();
        src_gaps  = 1'b1;
        sink_mode = SINK_OPEN;
        // the second header must replace the first one entirely
        feed_word(header_word(8'hFF, FILTER_QUAD_C, 4'd15), KIND_HEADER);
        feed_word(header_word(8'h00, FILTER_QUAD_B, 4'd3), KIND_HEADER);
        feed_word(16'h1F2E, KIND_DATA);
        wait_drained();
    endtask

    task automatic test_random_blocks(input int n_blocks);
        for (int b = 0; b < n_blocks; b++)
        begin
            if (b % 5 == 0)
            begin
                sink_mode = sink_mode_t'($urandom_range(0, 2));
                src_gaps  = 1'($urandom_range(0, 1));
            end
            send_block(7);
        end
        wait_drained();
    endtask

    task automatic test_random_noise(input int n_items);
        src_gaps  = 1'b1;
        sink_mode = SINK_RANDOM;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 10 == 0)
                send_block($urandom_range(0, 6));
            else
                feed_word(16'($urandom_range(0, 16'hFFFF)),
                          ($urandom_range(0, 3) == 0) ? KIND_HEADER : KIND_DATA);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        src_gaps  = 1'b0;
        sink_mode = SINK_OPEN;
        sink_hold = 300;
        repeat (3) send_block(7);
        wait_drained();
    endtask

    initial
    begin : sink
        int pattern_count;
        pattern_count = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            pattern_count++;
            if (sink_hold > 0)
            begin
                out_ready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                case (sink_mode)
                    SINK_RANDOM:  out_ready <= ($urandom_range(0, 2) != 0);
                    SINK_PATTERN: out_ready <= ((pattern_count % 7) > 2);
                    default:      out_ready <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : sample_checker
        pcm_sample_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pcm_expected.size() == 0)
                begin
                    $error("unexpected sample_out %0d with no sample pending", sample_out);
                    mismatch_count++;
                end
                else
                begin
                    want = pcm_expected.pop_front();
                    samples_checked++;
                    if (sample_out !== want.sample)
                    begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want.sample, sample_out);
                        mismatch_count++;
                    end
                    if (last_of_word !== want.last)
                    begin
                        $error("last_of_word mismatch: expected %0b, got %0b",
                               want.last, last_of_word);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin : run
        prev_sample      = '0;
        prev_prev_sample = '0;
        cur_shift        = '0;
        cur_filter       = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        word_in   <= '0;
        is_header <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_filters_and_shifts();
        test_saturation();
        test_header_runs();
        test_random_blocks(40);
        test_backpressure();
        test_random_noise(40);

        repeat (20) @(posedge clk);
        $display("Sent %0d words (%0d headers) and checked %0d samples across all filters,",
                 words_sent, headers_sent, samples_checked);
        $display("shifts 0 to 15, saturation, output stalls and a long receiver hold-off.");
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== adpcm_block_decoder.f =====
rtl/adpcm_pkg.sv
rtl/adpcm_front.sv
rtl/adpcm_back.sv
rtl/adpcm_block_decoder.sv
dv/adpcm_block_decoder_test.sv
